FILE: rtl/core/elg_pkg.sv
// Shared constants and types for the ElGamal rerandomization block.
`timescale 1ns / 1ps
package elg_pkg;
   localparam int MOD_BITS = 31;
   localparam int EXP_BITS = 32;
   localparam int C_BITS = 31;
   localparam int PROD_BITS = 2 * MOD_BITS;
   localparam int CNT_BITS = $clog2(PROD_BITS + 1);
   localparam int EXP_CNT_BITS = $clog2(EXP_BITS + 1);
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODULUS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GENERATOR = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PUBLIC = 2'd2;

   localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(10007);
   localparam logic [MOD_BITS-1:0] GENERATOR_RESET = MOD_BITS'(2);
   localparam logic [MOD_BITS-1:0] PUBLIC_RESET = MOD_BITS'(1);

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } lane_ctl_type;
endpackage

FILE: rtl/core/elg_if.sv
// Valid/ready channel interfaces for request and response transactions.
`timescale 1ns / 1ps
interface elg_req_if import elg_pkg::*; ();
   logic valid;
   logic ready;
   logic [C_BITS-1:0] first_part;
   logic [C_BITS-1:0] second_part;
   logic [EXP_BITS-1:0] fresh_exponent;
   modport source (output valid, first_part, second_part, fresh_exponent, input ready);
   modport sink (input valid, first_part, second_part, fresh_exponent, output ready);
endinterface

interface elg_rsp_if import elg_pkg::*; ();
   logic valid;
   logic ready;
   logic [C_BITS-1:0] new_first_part;
   logic [C_BITS-1:0] new_second_part;
   modport source (output valid, new_first_part, new_second_part, input ready);
   modport sink (input valid, new_first_part, new_second_part, output ready);
endinterface

FILE: rtl/core/elgamal_rerandomize.sv
// Top level: two lanes for the ciphertext components and a merging output register.
`timescale 1ns / 1ps
// Rerandomizes an ElGamal ciphertext: returns c1*g^r mod p and c2*h^r mod p, with
// (p, g, h) written through the csr_ port (index 0 modulus, 1 generator, 2 public value).
// Two lanes run in parallel, one per component, each with one iterative modular
// multiplier that forms the product in its S_MUL state and then reduces it one bit
// per cycle (steps of a multiply: issue, product, 62 reduction steps). A zero
// modulus gives zero results in the cycle after acceptance. A new request is
// accepted only once the previous result is taken.
module elgamal_rerandomize import elg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   elg_req_if.sink             req,
   elg_rsp_if.source           rsp,
   input  logic                csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [MOD_BITS-1:0] csr_wdata
);
   logic [MOD_BITS-1:0] mod_ff, mod_in, gen_ff, gen_in, pub_ff, pub_in;
   logic busy_ff, busy_in, start;
   logic out_valid_ff, out_valid_in;
   logic [C_BITS-1:0] out1_ff, out1_in, out2_ff, out2_in;
   lane_ctl_type ctl1, ctl2;
   logic [MOD_BITS-1:0] r1, r2;
   logic zero_mod;

   assign zero_mod = (mod_ff == '0);
   assign req.ready = !busy_ff && !out_valid_ff;
   assign start = req.valid && req.ready;

   elg_lane u_lane1 (
      .clock(clock), .reset(reset), .start(start && !zero_mod), .c_val(req.first_part),
      .base(gen_ff), .expo(req.fresh_exponent), .m(mod_ff), .ctl(ctl1), .result(r1)
   );
   elg_lane u_lane2 (
      .clock(clock), .reset(reset), .start(start && !zero_mod), .c_val(req.second_part),
      .base(pub_ff), .expo(req.fresh_exponent), .m(mod_ff), .ctl(ctl2), .result(r2)
   );

   always_comb begin
      mod_in = mod_ff;
      gen_in = gen_ff;
      pub_in = pub_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODULUS: mod_in = csr_wdata;
            CSR_GENERATOR: gen_in = csr_wdata;
            CSR_PUBLIC: pub_in = csr_wdata;
            default: ;
         endcase
      end
      busy_in = busy_ff;
      out_valid_in = out_valid_ff;
      out1_in = out1_ff;
      out2_in = out2_ff;
      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;
      if (start) begin
         if (zero_mod) begin
            out_valid_in = 1'b1;
            out1_in = '0;
            out2_in = '0;
         end else begin
            busy_in = 1'b1;
         end
      end
      if (busy_ff && ctl1.done && ctl2.done) begin
         busy_in = 1'b0;
         out_valid_in = 1'b1;
         out1_in = C_BITS'(r1);
         out2_in = C_BITS'(r2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET;
         gen_ff <= GENERATOR_RESET;
         pub_ff <= PUBLIC_RESET;
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mod_ff <= mod_in;
         gen_ff <= gen_in;
         pub_ff <= pub_in;
         busy_ff <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      out1_ff <= out1_in;
      out2_ff <= out2_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.new_first_part = out1_ff;
   assign rsp.new_second_part = out2_ff;
endmodule

FILE: rtl/core/elg_modmul.sv
// Iterative modular multiplier: product then bit-serial restoring reduction.
`timescale 1ns / 1ps
module elg_modmul import elg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MOD_BITS-1:0] a,
   input  logic [MOD_BITS-1:0] b,
   input  logic [MOD_BITS-1:0] m,
   output logic                done,
   output logic [MOD_BITS-1:0] result
);
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL  = 3'b010,
      S_RED  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [MOD_BITS:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [MOD_BITS-1:0] a_ff, a_in;
   logic [MOD_BITS-1:0] b_ff, b_in;
   logic [MOD_BITS:0] shifted;
   logic done_in, done_ff;

   always_comb begin
      state_in = state_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      a_in = a_ff;
      b_in = b_ff;
      done_in = 1'b0;
      shifted = {rem_ff[MOD_BITS-1:0], prod_ff[PROD_BITS-1]};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               a_in = a;
               b_in = b;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = PROD_BITS'(a_ff) * PROD_BITS'(b_ff);
            rem_in = '0;
            cnt_in = CNT_BITS'(PROD_BITS);
            state_in = S_RED;
         end
         S_RED: begin
            prod_in = {prod_ff[PROD_BITS-2:0], 1'b0};
            rem_in = (shifted >= {1'b0, m}) ? shifted - {1'b0, m} : shifted;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = S_IDLE;
               done_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign result = rem_ff[MOD_BITS-1:0];
endmodule

FILE: rtl/core/elg_lane.sv
// One lane: reduce c, compute c * base^r mod p by right-to-left square-and-multiply.
`timescale 1ns / 1ps
module elg_lane import elg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [C_BITS-1:0]   c_val,
   input  logic [MOD_BITS-1:0] base,
   input  logic [EXP_BITS-1:0] expo,
   input  logic [MOD_BITS-1:0] m,
   output lane_ctl_type        ctl,
   output logic [MOD_BITS-1:0] result
);
   typedef enum logic [6:0] {
      L_IDLE  = 7'b0000001,
      L_RBASE = 7'b0000010,
      L_RC    = 7'b0000100,
      L_MACC  = 7'b0001000,
      L_MSQ   = 7'b0010000,
      L_FINAL = 7'b0100000,
      L_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in, sq_ff, sq_in, c_ff, c_in;
   logic [EXP_BITS-1:0] e_ff, e_in;
   logic [EXP_CNT_BITS-1:0] bit_ff, bit_in;
   logic wait_ff, wait_in;
   logic mm_start;
   logic [MOD_BITS-1:0] mm_a;
   logic [MOD_BITS-1:0] mm_b, mm_r;
   logic mm_done;

   elg_modmul u_mul (
      .clock(clock), .reset(reset), .start(mm_start), .a(mm_a), .b(mm_b),
      .m(m), .done(mm_done), .result(mm_r)
   );

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      sq_in = sq_ff;
      c_in = c_ff;
      e_in = e_ff;
      bit_in = bit_ff;
      wait_in = wait_ff;
      mm_start = 1'b0;
      mm_a = '0;
      mm_b = '0;
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               e_in = expo;
               c_in = MOD_BITS'(c_val);
               sq_in = base;
               acc_in = MOD_BITS'(1);
               bit_in = '0;
               wait_in = 1'b0;
               state_in = L_RBASE;
            end
         end
         L_RBASE: begin
            mm_a = sq_ff;
            mm_b = MOD_BITS'(1);
            if (!wait_ff) begin
               mm_start = 1'b1;
               wait_in = 1'b1;
            end else if (mm_done) begin
               sq_in = mm_r;
               wait_in = 1'b0;
               state_in = L_RC;
            end
         end
         L_RC: begin
            mm_a = c_ff;
            mm_b = MOD_BITS'(1);
            if (!wait_ff) begin
               mm_start = 1'b1;
               wait_in = 1'b1;
            end else if (mm_done) begin
               c_in = mm_r;
               wait_in = 1'b0;
               state_in = L_MACC;
            end
         end
         L_MACC: begin
            mm_a = acc_ff;
            mm_b = e_ff[0] ? sq_ff : MOD_BITS'(1);
            if (!wait_ff) begin
               mm_start = 1'b1;
               wait_in = 1'b1;
            end else if (mm_done) begin
               acc_in = mm_r;
               wait_in = 1'b0;
               state_in = L_MSQ;
            end
         end
         L_MSQ: begin
            mm_a = sq_ff;
            mm_b = sq_ff;
            if (!wait_ff) begin
               mm_start = 1'b1;
               wait_in = 1'b1;
            end else if (mm_done) begin
               sq_in = mm_r;
               wait_in = 1'b0;
               e_in = e_ff >> 1;
               bit_in = bit_ff + 1'b1;
               state_in = (bit_ff == EXP_CNT_BITS'(EXP_BITS - 1)) ? L_FINAL : L_MACC;
            end
         end
         L_FINAL: begin
            mm_a = c_ff;
            mm_b = acc_ff;
            if (!wait_ff) begin
               mm_start = 1'b1;
               wait_in = 1'b1;
            end else if (mm_done) begin
               acc_in = mm_r;
               wait_in = 1'b0;
               state_in = L_DONE;
            end
         end
         L_DONE: state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
      end
      acc_ff <= acc_in;
      sq_ff <= sq_in;
      c_ff <= c_in;
      e_ff <= e_in;
      bit_ff <= bit_in;
   end

   assign ctl.start = start;
   assign ctl.busy = (state_ff != L_IDLE);
   assign ctl.done = (state_ff == L_DONE);
   assign result = acc_ff;
endmodule

FILE: tb/tb.sv
// Self-checking testbench for the ElGamal ciphertext rerandomization block.
`timescale 1ns / 1ps
module tb;
   import elg_pkg::*;

   typedef struct {
      logic [C_BITS-1:0]   first_part;
      logic [C_BITS-1:0]   second_part;
      logic [EXP_BITS-1:0] fresh_exponent;
   } cipher_req_type;

   typedef struct {
      logic [C_BITS-1:0] new_first_part;
      logic [C_BITS-1:0] new_second_part;
   } cipher_rsp_type;

   localparam int CYCLE_LIMIT = 5000000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_MODULUS;
   logic [MOD_BITS-1:0] csr_wdata = '0;

   elg_req_if req_ch ();
   elg_rsp_if rsp_ch ();

   elgamal_rerandomize dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   cipher_req_type pending_reqs[$];
   cipher_rsp_type expected_rsps[$];
   logic [MOD_BITS-1:0] key_modulus = MODULUS_RESET;
   logic [MOD_BITS-1:0] key_generator = GENERATOR_RESET;
   logic [MOD_BITS-1:0] key_public = PUBLIC_RESET;
   int send_idle_pct = 38;
   int recv_idle_pct = 76;
   int hold_left = 0;
   int fail_count = 0;
   int cycle_count = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned mod_power(longint unsigned base,
                                                 logic [EXP_BITS-1:0] e,
                                                 longint unsigned m);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1 % m;
      sq = base % m;
      for (int b = 0; b < EXP_BITS; b++) begin
         if (e[b]) acc = (acc * sq) % m;
         sq = (sq * sq) % m;
      end
      return acc;
   endfunction

   function automatic cipher_rsp_type rerandomize(cipher_req_type t);
      cipher_rsp_type r;
      longint unsigned m;
      m = key_modulus;
      r.new_first_part = '0;
      r.new_second_part = '0;
      if (m != 0) begin
         r.new_first_part = C_BITS'(((t.first_part % m)
            * mod_power(key_generator, t.fresh_exponent, m)) % m);
         r.new_second_part = C_BITS'(((t.second_part % m)
            * mod_power(key_public, t.fresh_exponent, m)) % m);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.first_part <= '0;
         req_ch.second_part <= '0;
         req_ch.fresh_exponent <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_rsps.push_back(rerandomize('{req_ch.first_part, req_ch.second_part,
                                                  req_ch.fresh_exponent}));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cipher_req_type t;
               t = pending_reqs.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.first_part <= t.first_part;
               req_ch.second_part <= t.second_part;
               req_ch.fresh_exponent <= t.fresh_exponent;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_ch.new_first_part, 0);
            end else begin
               cipher_rsp_type w;
               w = expected_rsps.pop_front();
               if (rsp_ch.new_first_part !== w.new_first_part)
                  report_mismatch("new_first_part", rsp_ch.new_first_part,
                                  w.new_first_part);
               if (rsp_ch.new_second_part !== w.new_second_part)
                  report_mismatch("new_second_part", rsp_ch.new_second_part,
                                  w.new_second_part);
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [MOD_BITS-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_MODULUS) key_modulus = val;
      else if (idx == CSR_GENERATOR) key_generator = val;
      else if (idx == CSR_PUBLIC) key_public = val;
   endtask

   task automatic set_key(logic [MOD_BITS-1:0] p, logic [MOD_BITS-1:0] g,
                          logic [MOD_BITS-1:0] h);
      write_reg(CSR_MODULUS, p);
      write_reg(CSR_GENERATOR, g);
      write_reg(CSR_PUBLIC, h);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_req(logic [C_BITS-1:0] c1, logic [C_BITS-1:0] c2,
                          logic [EXP_BITS-1:0] e);
      pending_reqs.push_back('{c1, c2, e});
   endtask

   task automatic add_random(int n);
      logic [C_BITS-1:0] c1;
      logic [C_BITS-1:0] c2;
      logic [EXP_BITS-1:0] e;
      for (int i = 0; i < n; i++) begin
         c1 = C_BITS'($urandom);
         c2 = C_BITS'($urandom);
         if ($urandom_range(3) == 0) c1 = C_BITS'(key_modulus + $urandom_range(2) - 1);
         if ($urandom_range(3) == 0) c2 = C_BITS'($urandom_range(3));
         e = $urandom;
         if ($urandom_range(4) == 0) e = $urandom_range(5);
         add_req(c1, c2, e);
      end
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset key, directed corners
      add_req('0, '0, '0);
      add_req('1, '1, '0);
      add_req('1, '1, '1);
      add_req(31'd1, 31'd1, 32'd1);
      add_req(31'd10006, 31'd10007, 32'd2);
      add_req(31'd10008, 31'd20014, 32'h8000_0000);
      add_req(31'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA);
      add_req(31'h2AAA_AAAA, 31'h5555_5555, 32'h5555_5555);
      add_req(31'd12345, 31'd0, 32'd10006);
      add_req(31'd0, 31'd9999, 32'hFFFF_FFFE);
      add_random(15);
      drain();

      for (int grp = 1; grp <= 8; grp++) begin
         if (grp >= 3) begin
            send_idle_pct = 76;
            recv_idle_pct = 38;
         end
         if (grp >= 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (grp)
            1: set_key(31'd3, 31'd2, 31'd1);
            2: begin
               set_key(31'h7FFF_FFFF, 31'h7FFF_FFFE, MOD_BITS'($urandom));
               write_reg(CSR_UNUSED, MOD_BITS'($urandom));
               @(posedge clock);
               csr_we <= 1'b0;
            end
            3: set_key('0, 31'd5, 31'd9);
            4: set_key(31'd1, MOD_BITS'($urandom), MOD_BITS'($urandom));
            5: set_key(31'd2, 31'd1, '0);
            6: set_key(31'd1000000, MOD_BITS'($urandom), MOD_BITS'($urandom));
            7: set_key(MOD_BITS'($urandom) | 31'd1, '0, 31'h7FFF_FFFF);
            default: set_key(MOD_BITS'($urandom), MOD_BITS'($urandom),
                             MOD_BITS'($urandom));
         endcase
         if (grp == 1) hold_left = 15000;
         add_random(31);
         drain();
      end

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

FILE: files.f
rtl/core/elg_pkg.sv
rtl/core/elg_if.sv
rtl/core/elg_modmul.sv
rtl/core/elg_lane.sv
rtl/core/elgamal_rerandomize.sv
tb/tb.sv
